@@ hdl/drwcg_pkg.sv @@
// Shared types and constants of the rectangle window command generator.
package drwcg_pkg;

    localparam logic [1:0] ACT_FILL   = 2'd0;
    localparam logic [1:0] ACT_BITMAP = 2'd1;
    localparam logic [1:0] ACT_SCROLL = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;
    localparam logic [1:0] KIND_BITMAP = 2'd3;

    localparam logic [7:0] CMD_COLSET   = 8'h2A;
    localparam logic [7:0] CMD_PAGESET  = 8'h2B;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
    localparam logic [7:0] CMD_SCROLL   = 8'h37;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [2:0] SLOT_COL_CMD  = 3'd0;
    localparam logic [2:0] SLOT_COL_DATA = 3'd1;
    localparam logic [2:0] SLOT_ROW_CMD  = 3'd2;
    localparam logic [2:0] SLOT_ROW_DATA = 3'd3;
    localparam logic [2:0] SLOT_MEM_CMD  = 3'd4;
    localparam logic [2:0] SLOT_PAYLOAD  = 3'd5;

    typedef struct packed {
        logic        vis;
        logic [8:0]  start;
        logic [8:0]  size;
        logic [8:0]  stop;
        logic [15:0] skip;
    } clip_t;

endpackage

@@ hdl/drwcg_req_if.sv @@
// Request channel carrying one drawing request per word.
interface drwcg_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] size_w;
    logic signed [15:0] size_h;
    logic [15:0]        fill_color;

    modport source (
        output valid, action, pos_x, pos_y, size_w, size_h, fill_color,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, size_w, size_h, fill_color,
        output ready
    );
endinterface

@@ hdl/drwcg_rsp_if.sv @@
// Descriptor channel carrying one transaction descriptor per word.
interface drwcg_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [31:0] data_word;
    logic [17:0] pixel_count;
    logic [8:0]  row_count;
    logic [7:0]  red_byte;
    logic [7:0]  green_byte;
    logic [7:0]  blue_byte;
    logic [30:0] source_offset;
    logic [14:0] source_stride;
    logic        last;

    modport source (
        output valid, item_kind, data_word, pixel_count, row_count, red_byte,
               green_byte, blue_byte, source_offset, source_stride, last,
        input  ready
    );
    modport sink (
        input  valid, item_kind, data_word, pixel_count, row_count, red_byte,
               green_byte, blue_byte, source_offset, source_stride, last,
        output ready
    );
endinterface

@@ hdl/display_rect_window_command_gen_top.sv @@
// Top level of the rectangle clip and address window command generator.
//
// A fill or bitmap request that survives clipping becomes six descriptor words
// (column set, column window, page set, row window, memory write, colour run or
// bitmap descriptor); a scroll becomes two words; a request that is clipped
// away or carries an unknown action is consumed without output. Words leave
// one per cycle while the receiver is ready, from a single output register;
// the next request waits clipped in the input register. Each request passes
// through the input and work registers before its first word is registered.
// The screen size registers are written through the APB port; the user must
// write them only while the block is idle, which the block does not enforce.
module display_rect_window_command_gen_top #(
    parameter int PANEL_LONG  = 480,
    parameter int PANEL_SHORT = 320
) (
    input  logic        clk,
    input  logic        rst_n,
    drwcg_req_if.sink   req,
    drwcg_rsp_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drwcg_pkg::*;

    localparam logic [8:0] WIDTH_RST  = (PANEL_LONG > 511) ? 9'd511 : 9'(PANEL_LONG);
    localparam logic [8:0] HEIGHT_RST = (PANEL_SHORT > 511) ? 9'd511 : 9'(PANEL_SHORT);

    logic [8:0] scr_w_reg;
    logic [8:0] scr_h_reg;
    logic       cfg_wr;

    logic               in_vld_reg;
    logic [1:0]         in_act_reg;
    logic signed [15:0] in_x_reg;
    logic signed [15:0] in_y_reg;
    logic signed [15:0] in_w_reg;
    logic signed [15:0] in_h_reg;
    logic [15:0]        in_col_reg;

    clip_t clip_x;
    clip_t clip_y;
    logic  in_drop;
    logic  in_adv;
    logic  wrk_load;

    logic               wrk_vld_reg;
    logic [2:0]         wrk_idx_reg;
    logic [1:0]         wrk_act_reg;
    logic [8:0]         wrk_cx_reg;
    logic [8:0]         wrk_cxe_reg;
    logic [8:0]         wrk_cw_reg;
    logic [8:0]         wrk_cy_reg;
    logic [8:0]         wrk_cye_reg;
    logic [8:0]         wrk_ch_reg;
    logic [15:0]        wrk_bx_reg;
    logic [15:0]        wrk_by_reg;
    logic signed [15:0] wrk_sw_reg;
    logic [15:0]        wrk_col_reg;
    logic [15:0]        wrk_line_reg;
    logic [2:0]         wrk_last_idx;
    logic               step;
    logic               wrk_done;

    logic signed [32:0] off_prod;
    logic [17:0]        pix_prod;

    logic        out_vld_reg;
    logic        out_vld_next;
    logic [1:0]  out_kind_next;
    logic [31:0] out_word_next;
    logic [17:0] out_pix_next;
    logic [8:0]  out_rows_next;
    logic [7:0]  out_r_next;
    logic [7:0]  out_g_next;
    logic [7:0]  out_b_next;
    logic [30:0] out_off_next;
    logic [14:0] out_stride_next;
    logic        out_last_next;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_word_reg;
    logic [17:0] out_pix_reg;
    logic [8:0]  out_rows_reg;
    logic [7:0]  out_r_reg;
    logic [7:0]  out_g_reg;
    logic [7:0]  out_b_reg;
    logic [30:0] out_off_reg;
    logic [14:0] out_stride_reg;
    logic        out_last_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SCREEN_HEIGHT) ? {23'd0, scr_h_reg} : {23'd0, scr_w_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= WIDTH_RST;
            scr_h_reg <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SCREEN_WIDTH)
            begin
                scr_w_reg <= pwdata[8:0];
            end
            else
            begin
                scr_h_reg <= pwdata[8:0];
            end
        end
    end

    drwcg_clip_axis u_clip_x (
        .pos  (in_x_reg),
        .size (in_w_reg),
        .lim  (scr_w_reg),
        .res  (clip_x)
    );

    drwcg_clip_axis u_clip_y (
        .pos  (in_y_reg),
        .size (in_h_reg),
        .lim  (scr_h_reg),
        .res  (clip_y)
    );

    assign in_drop = (in_act_reg == ACT_NONE)
                  || ((in_act_reg != ACT_SCROLL) && !(clip_x.vis && clip_y.vis));
    assign wrk_last_idx = (wrk_act_reg == ACT_SCROLL) ? SLOT_COL_DATA : SLOT_PAYLOAD;
    assign step     = wrk_vld_reg && (!out_vld_reg || rsp.ready);
    assign wrk_done = step && (wrk_idx_reg == wrk_last_idx);
    assign in_adv   = in_vld_reg && (in_drop || !wrk_vld_reg || wrk_done);
    assign wrk_load = in_adv && !in_drop;
    assign req.ready = !in_vld_reg || in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_act_reg <= req.action;
            in_x_reg   <= req.pos_x;
            in_y_reg   <= req.pos_y;
            in_w_reg   <= req.size_w;
            in_h_reg   <= req.size_h;
            in_col_reg <= req.fill_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrk_vld_reg <= 1'b0;
            wrk_idx_reg <= SLOT_COL_CMD;
        end
        else if (wrk_load)
        begin
            wrk_vld_reg <= 1'b1;
            wrk_idx_reg <= SLOT_COL_CMD;
        end
        else if (wrk_done)
        begin
            wrk_vld_reg <= 1'b0;
        end
        else if (step)
        begin
            wrk_idx_reg <= wrk_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wrk_load)
        begin
            wrk_act_reg  <= in_act_reg;
            wrk_cx_reg   <= clip_x.start;
            wrk_cxe_reg  <= clip_x.stop;
            wrk_cw_reg   <= clip_x.size;
            wrk_cy_reg   <= clip_y.start;
            wrk_cye_reg  <= clip_y.stop;
            wrk_ch_reg   <= clip_y.size;
            wrk_bx_reg   <= clip_x.skip;
            wrk_by_reg   <= clip_y.skip;
            wrk_sw_reg   <= in_w_reg;
            wrk_col_reg  <= in_col_reg;
            wrk_line_reg <= in_y_reg;
        end
    end

    assign off_prod = $signed({1'b0, wrk_by_reg}) * wrk_sw_reg;
    assign pix_prod = wrk_cw_reg * wrk_ch_reg;

    always_comb
    begin
        out_kind_next   = KIND_CMD;
        out_word_next   = 32'd0;
        out_pix_next    = 18'd0;
        out_rows_next   = 9'd0;
        out_r_next      = 8'd0;
        out_g_next      = 8'd0;
        out_b_next      = 8'd0;
        out_off_next    = 31'd0;
        out_stride_next = 15'd0;
        out_last_next   = 1'b0;
        if (wrk_act_reg == ACT_SCROLL)
        begin
            if (wrk_idx_reg == SLOT_COL_CMD)
            begin
                out_word_next = {24'd0, CMD_SCROLL};
            end
            else
            begin
                out_kind_next = KIND_DATA;
                out_word_next = {16'd0, wrk_line_reg};
                out_last_next = 1'b1;
            end
        end
        else
        begin
            unique case (wrk_idx_reg)
                SLOT_COL_CMD:
                begin
                    out_word_next = {24'd0, CMD_COLSET};
                end
                SLOT_COL_DATA:
                begin
                    out_kind_next = KIND_DATA;
                    out_word_next = {7'd0, wrk_cx_reg, 7'd0, wrk_cxe_reg};
                end
                SLOT_ROW_CMD:
                begin
                    out_word_next = {24'd0, CMD_PAGESET};
                end
                SLOT_ROW_DATA:
                begin
                    out_kind_next = KIND_DATA;
                    out_word_next = {7'd0, wrk_cy_reg, 7'd0, wrk_cye_reg};
                end
                SLOT_MEM_CMD:
                begin
                    out_word_next = {24'd0, CMD_MEMWRITE};
                end
                default:
                begin
                    out_last_next = 1'b1;
                    if (wrk_act_reg == ACT_FILL)
                    begin
                        out_kind_next = KIND_RUN;
                        out_pix_next  = pix_prod;
                        out_r_next    = {wrk_col_reg[15:11], 3'd0};
                        out_g_next    = {wrk_col_reg[10:5], 2'd0};
                        out_b_next    = {wrk_col_reg[4:0], 3'd0};
                    end
                    else
                    begin
                        out_kind_next   = KIND_BITMAP;
                        out_pix_next    = {9'd0, wrk_cw_reg};
                        out_rows_next   = wrk_ch_reg;
                        out_off_next    = off_prod[30:0] + {15'd0, wrk_bx_reg};
                        out_stride_next = wrk_sw_reg[14:0];
                    end
                end
            endcase
        end
    end

    assign out_vld_next = step || (out_vld_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_kind_reg   <= out_kind_next;
            out_word_reg   <= out_word_next;
            out_pix_reg    <= out_pix_next;
            out_rows_reg   <= out_rows_next;
            out_r_reg      <= out_r_next;
            out_g_reg      <= out_g_next;
            out_b_reg      <= out_b_next;
            out_off_reg    <= out_off_next;
            out_stride_reg <= out_stride_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.item_kind     = out_kind_reg;
    assign rsp.data_word     = out_word_reg;
    assign rsp.pixel_count   = out_pix_reg;
    assign rsp.row_count     = out_rows_reg;
    assign rsp.red_byte      = out_r_reg;
    assign rsp.green_byte    = out_g_reg;
    assign rsp.blue_byte     = out_b_reg;
    assign rsp.source_offset = out_off_reg;
    assign rsp.source_stride = out_stride_reg;
    assign rsp.last          = out_last_reg;

endmodule

@@ hdl/drwcg_clip_axis.sv @@
// Clipping of one axis of a request rectangle against a screen dimension.
module drwcg_clip_axis (
    input  logic signed [15:0] pos,
    input  logic signed [15:0] size,
    input  logic [8:0]         lim,
    output drwcg_pkg::clip_t   res
);
    import drwcg_pkg::*;

    logic [15:0] edge_pos;
    logic [15:0] size_lt;
    logic [8:0]  start;
    logic [8:0]  size_c;
    logic        off_hi;
    logic        edge_hi;
    logic        size_pos;

    assign edge_pos = pos + size - 16'd1;
    assign size_lt  = pos[15] ? (edge_pos + 16'd1) : size;
    assign start    = pos[15] ? 9'd0 : pos[8:0];
    assign off_hi   = !pos[15] && (pos[14:0] >= {6'd0, lim});
    assign edge_hi  = !edge_pos[15] && (edge_pos[14:0] >= {6'd0, lim});
    assign size_pos = !size_lt[15] && (size_lt != 16'd0);
    assign size_c   = edge_hi ? (lim - start) : size_lt[8:0];

    assign res.vis   = !off_hi && !edge_pos[15] && (edge_hi ? (size_c != 9'd0) : size_pos);
    assign res.start = start;
    assign res.size  = size_c;
    assign res.stop  = start + size_c - 9'd1;
    assign res.skip  = pos[15] ? (16'd0 - pos) : 16'd0;

endmodule

@@ tb/display_rect_window_command_gen_top_tb.sv @@
// Testbench checking the descriptors of the rectangle window command generator against a predictor.
module display_rect_window_command_gen_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drwcg_pkg::*;

    localparam logic [2:0] ADDR_SCREEN_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_SCREEN_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
        logic [15:0]        color;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word;
        logic [17:0] pixels;
        logic [8:0]  rows;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [30:0] offset;
        logic [14:0] stride;
        logic        last;
    } descriptor_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drwcg_req_if req_ch ();
    drwcg_rsp_if rsp_ch ();

    display_rect_window_command_gen_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    request_t    request_backlog[$];
    descriptor_t expected_descriptors[$];
    request_t    request_on_bus;
    int          screen_w_cfg;
    int          screen_h_cfg;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatch_count;
    int          hold_req;
    int          hold_ack;
    int          hold_left;

    always #4 clk = ~clk;

    function automatic int sx16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return t;
    endfunction

    function automatic bit clip_span(input int p, input int s, input int lim,
                                     output int cp, output int cs, output int skip);
        int e;
        cp = 0;
        cs = 0;
        skip = 0;
        if (p >= lim)
            return 1'b0;
        e = sx16(p + s - 1);
        if (e < 0)
            return 1'b0;
        if (p < 0)
        begin
            skip = -p;
            s = sx16(e + 1);
            p = 0;
        end
        if (e >= lim)
            s = lim - p;
        cp = p;
        cs = s;
        return s > 0;
    endfunction

    function automatic descriptor_t plain_desc(input logic [1:0] kind,
                                               input logic [31:0] word, input logic last);
        descriptor_t d;
        d = '0;
        d.kind = kind;
        d.word = word;
        d.last = last;
        return d;
    endfunction

    function automatic void predict_descriptors(input request_t r);
        int          cx, cy, cw, ch, bx, by;
        logic [31:0] off;
        descriptor_t d;
        if (r.action == ACT_SCROLL)
        begin
            expected_descriptors.push_back(plain_desc(KIND_CMD, 32'(CMD_SCROLL), 1'b0));
            expected_descriptors.push_back(plain_desc(KIND_DATA, {16'h0000, r.pos_y}, 1'b1));
            return;
        end
        if (r.action == ACT_NONE)
            return;
        if (!clip_span(r.pos_x, r.size_w, screen_w_cfg, cx, cw, bx))
            return;
        if (!clip_span(r.pos_y, r.size_h, screen_h_cfg, cy, ch, by))
            return;
        expected_descriptors.push_back(plain_desc(KIND_CMD, 32'(CMD_COLSET), 1'b0));
        expected_descriptors.push_back(plain_desc(KIND_DATA,
                                                  {cx[15:0], 16'(cx + cw - 1)}, 1'b0));
        expected_descriptors.push_back(plain_desc(KIND_CMD, 32'(CMD_PAGESET), 1'b0));
        expected_descriptors.push_back(plain_desc(KIND_DATA,
                                                  {cy[15:0], 16'(cy + ch - 1)}, 1'b0));
        expected_descriptors.push_back(plain_desc(KIND_CMD, 32'(CMD_MEMWRITE), 1'b0));
        d = '0;
        d.last = 1'b1;
        if (r.action == ACT_FILL)
        begin
            d.kind = KIND_RUN;
            d.pixels = 18'(cw * ch);
            d.red = {r.color[15:11], 3'b000};
            d.green = {r.color[10:5], 2'b00};
            d.blue = {r.color[4:0], 3'b000};
        end
        else
        begin
            off = by * int'(r.size_w) + bx;
            d.kind = KIND_BITMAP;
            d.pixels = 18'(cw);
            d.rows = 9'(ch);
            d.offset = off[30:0];
            d.stride = r.size_w[14:0];
        end
        expected_descriptors.push_back(d);
    endfunction

    always @(posedge clk)
    begin : drive_requests
        request_t nxt;
        if (req_ch.valid && req_ch.ready)
            predict_descriptors(request_on_bus);
        if (!req_ch.valid || req_ch.ready)
        begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = request_backlog.pop_front();
                request_on_bus <= nxt;
                req_ch.valid <= 1'b1;
                req_ch.action <= nxt.action;
                req_ch.pos_x <= nxt.pos_x;
                req_ch.pos_y <= nxt.pos_y;
                req_ch.size_w <= nxt.size_w;
                req_ch.size_h <= nxt.size_h;
                req_ch.fill_color <= nxt.color;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req != hold_ack)
        begin
            hold_left <= HOLD_CYCLES;
            hold_ack <= hold_req;
        end
    end

    always @(posedge clk)
    begin : check_descriptors
        descriptor_t got;
        descriptor_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.kind = rsp_ch.item_kind;
            got.word = rsp_ch.data_word;
            got.pixels = rsp_ch.pixel_count;
            got.rows = rsp_ch.row_count;
            got.red = rsp_ch.red_byte;
            got.green = rsp_ch.green_byte;
            got.blue = rsp_ch.blue_byte;
            got.offset = rsp_ch.source_offset;
            got.stride = rsp_ch.source_stride;
            got.last = rsp_ch.last;
            if (expected_descriptors.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected descriptor word: %p", got);
                mismatch_count++;
            end
            else
            begin
                want = expected_descriptors.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                        $display("descriptor mismatch: expected %p got %p", want, got);
                    mismatch_count++;
                end
            end
        end
        rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_screen(input int w, input int h);
        apb_write(ADDR_SCREEN_WIDTH, 32'(w));
        screen_w_cfg = w;
        apb_write(ADDR_SCREEN_HEIGHT, 32'(h));
        screen_h_cfg = h;
    endtask

    task automatic wait_until_quiet();
        while (request_backlog.size() != 0 || req_ch.valid || expected_descriptors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_req(input logic [1:0] action, input int px, input int py,
                                     input int sw, input int sh, input logic [15:0] color);
        request_t r;
        r.action = action;
        r.pos_x = 16'(px);
        r.pos_y = 16'(py);
        r.size_w = 16'(sw);
        r.size_h = 16'(sh);
        r.color = color;
        request_backlog.push_back(r);
    endfunction

    task automatic queue_random(input int count);
        request_t r;
        int       made;
        int       pick;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            r.action = $urandom_range(1) ? ACT_FILL : ACT_BITMAP;
            r.color = 16'($urandom);
            if (pick < 60)
            begin
                r.pos_x = 16'(int'($urandom_range(0, 2 * screen_w_cfg)) - screen_w_cfg / 2);
                r.pos_y = 16'(int'($urandom_range(0, 2 * screen_h_cfg)) - screen_h_cfg / 2);
                r.size_w = 16'($urandom_range(1, screen_w_cfg + 8));
                r.size_h = 16'($urandom_range(1, screen_h_cfg + 8));
            end
            else
            begin
                r.pos_x = 16'($urandom);
                r.pos_y = 16'($urandom);
                r.size_w = 16'($urandom);
                r.size_h = 16'($urandom);
                if (pick < 75)
                    r.action = ACT_SCROLL;
                else if (pick < 82)
                    r.action = ACT_NONE;
            end
            request_backlog.push_back(r);
            if (r.action != ACT_NONE)
                made++;
        end
    endtask

    task automatic run_phase(input int w, input int h, input int send_pct,
                             input int recv_pct, input int count);
        set_screen(w, h);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(count);
        wait_until_quiet();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_FILL;
        req_ch.pos_x = '0;
        req_ch.pos_y = '0;
        req_ch.size_w = '0;
        req_ch.size_h = '0;
        req_ch.fill_color = '0;
        rsp_ch.ready = 1'b0;
        request_on_bus = '0;
        screen_w_cfg = 480;
        screen_h_cfg = 320;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_req(ACT_FILL, 0, 0, 480, 320, 16'hFFFF);
        push_req(ACT_FILL, 0, 0, 1, 1, 16'h0000);
        push_req(ACT_FILL, 479, 319, 1, 1, 16'hF800);
        push_req(ACT_FILL, 480, 0, 10, 10, 16'h1234);
        push_req(ACT_FILL, 0, 320, 10, 10, 16'h4321);
        push_req(ACT_FILL, -10, -10, 5, 5, 16'h5555);
        push_req(ACT_FILL, -10, -5, 20, 15, 16'h07E0);
        push_req(ACT_FILL, 470, 310, 100, 100, 16'h001F);
        push_req(ACT_FILL, -32768, -32768, 32767, 32767, 16'h8001);
        push_req(ACT_FILL, -32768, -32768, -1, -1, 16'h7FFE);
        push_req(ACT_FILL, 0, 0, 32767, 32767, 16'hAAAA);
        push_req(ACT_FILL, 5, 5, 32767, 2, 16'h0F0F);
        push_req(ACT_FILL, 0, 0, 0, 5, 16'hF0F0);
        push_req(ACT_FILL, 10, 10, -5, 3, 16'hC3C3);
        push_req(ACT_BITMAP, 100, 50, 64, 32, 16'h0000);
        push_req(ACT_BITMAP, -5, -3, 20, 10, 16'h0000);
        push_req(ACT_BITMAP, -32768, -32768, -1, -1, 16'h0000);
        push_req(ACT_BITMAP, 32767, 32767, 32767, 32767, 16'h0000);
        push_req(ACT_BITMAP, 0, 0, -32768, 1, 16'h0000);
        push_req(ACT_SCROLL, 0, 0, 0, 0, 16'h0000);
        push_req(ACT_SCROLL, 0, -1, 0, 0, 16'h0000);
        push_req(ACT_SCROLL, 0, 32767, 0, 0, 16'h0000);
        push_req(ACT_SCROLL, 0, -32768, 0, 0, 16'h0000);
        push_req(ACT_NONE, 3, 3, 8, 8, 16'hFFFF);
        push_req(ACT_FILL, 0, 0, 4, 4, 16'h1111);
        wait_until_quiet();

        run_phase(480, 320, 0, 0, 60);
        run_phase(1, 1, 78, 0, 40);
        run_phase(480, 480, 0, 78, 60);
        run_phase($urandom_range(1, 480), $urandom_range(1, 480), 22, 22, 50);

        set_screen(320, 480);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        queue_random(60);
        wait_until_quiet();

        run_phase($urandom_range(1, 480), $urandom_range(1, 480), 22, 22, 50);
        run_phase(37, 480, 78, 0, 40);

        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_descriptors.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
